### hw/rtl/gha_pkg.sv
// Shared constants, codes and types of the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

	// Fixed field widths of the request and result channels.
	localparam int REQ_W    = 3;
	localparam int HIDX_W   = 10;
	localparam int HGEN_W   = 16;
	localparam int STATUS_W = 2;
	localparam int LIVE_W   = 11;

	// Default sizes handed to the top level parameters.
	localparam int SLOT_COUNT_DEF    = 1024;
	localparam int GEN_BITS_DEF      = 16;
	localparam int PENDING_DEPTH_DEF = 1024;

	typedef logic [REQ_W-1:0]    req_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam req_t REQ_ALLOC = 3'd0;
	localparam req_t REQ_MARK  = 3'd1;
	localparam req_t REQ_FLUSH = 3'd2;
	localparam req_t REQ_LOOK  = 3'd3;
	localparam req_t REQ_CLEAR = 3'd4;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_NOFREE = 2'd1;
	localparam status_t ST_STALE  = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	typedef struct packed {
		status_t             status;
		logic [HIDX_W-1:0]   out_index;
		logic [HGEN_W-1:0]   out_generation;
		logic                present;
		logic                alive;
		logic [LIVE_W-1:0]   live_count;
	} result_t;

endpackage

### hw/rtl/gha_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gha_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/gha_ctrl.sv
// Request sequencer: read-modify-write of slot records, free stack and pending list.
`timescale 1ns / 1ps

module gha_ctrl #(
	parameter int SLOT_COUNT    = gha_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS      = gha_pkg::GEN_BITS_DEF,
	parameter int PENDING_DEPTH = gha_pkg::PENDING_DEPTH_DEF,
	localparam int IW  = $clog2(SLOT_COUNT),
	localparam int CW  = $clog2(SLOT_COUNT + 1),
	localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
	localparam int SW  = GEN_BITS + 2,
	localparam int FW  = IW + GEN_BITS,
	localparam int PDW = gha_pkg::HIDX_W + gha_pkg::HGEN_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  gha_pkg::req_t               req_type,
	input  logic [gha_pkg::HIDX_W-1:0]  handle_index,
	input  logic [gha_pkg::HGEN_W-1:0]  handle_generation,
	input  logic                        out_free,
	output logic                        res_valid,
	output gha_pkg::result_t            res_out,
	output logic                        slot_we,
	output logic [IW-1:0]               slot_waddr,
	output logic [SW-1:0]               slot_wdata,
	output logic [IW-1:0]               slot_raddr,
	input  logic [SW-1:0]               slot_rdata,
	output logic                        free_we,
	output logic [IW-1:0]               free_waddr,
	output logic [FW-1:0]               free_wdata,
	output logic [IW-1:0]               free_raddr,
	input  logic [FW-1:0]               free_rdata,
	output logic                        pend_we,
	output logic [PAW-1:0]              pend_waddr,
	output logic [PDW-1:0]              pend_wdata,
	output logic [PAW-1:0]              pend_raddr,
	input  logic [PDW-1:0]              pend_rdata
);

	localparam int PW  = $clog2(PENDING_DEPTH + 1);
	localparam int CGW = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_ALLOC = 9'b000000100,
		S_MARK  = 9'b000001000,
		S_LOOK  = 9'b000010000,
		S_FLP   = 9'b000100000,
		S_FLS   = 9'b001000000,
		S_CLR   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t                      state_q, state_d;
	logic [IW-1:0]               ctr_q, ctr_d;
	logic [CW-1:0]               free_count_q, free_count_d;
	logic [PW-1:0]               pend_count_q, pend_count_d;
	logic [PW-1:0]               fl_ptr_q, fl_ptr_d, fl_ptr_next;
	logic [gha_pkg::HIDX_W-1:0]  hidx_q;
	logic [gha_pkg::HGEN_W-1:0]  hgen_q;
	logic [IW-1:0]               fl_idx_q, fl_idx_d;
	logic [gha_pkg::HGEN_W-1:0]  fl_gen_q, fl_gen_d;
	gha_pkg::result_t            res_q, res_d;
	logic                        fin;
	logic [CW-1:0]               live_full;

	// Fields of the slot record, the popped free entry and the pending entry.
	logic                        s_occ, s_alive;
	logic [GEN_BITS-1:0]         s_gen, a_gen, gen_new;
	logic [IW-1:0]               a_idx;
	logic [gha_pkg::HIDX_W-1:0]  p_idx;
	logic [gha_pkg::HGEN_W-1:0]  p_gen;
	logic                        hit_req, hit_fl;

	assign {s_occ, s_alive, s_gen} = slot_rdata;
	assign {a_idx, a_gen}          = free_rdata;
	assign {p_idx, p_gen}          = pend_rdata;
	assign gen_new                 = a_gen + 1'b1;
	assign hit_req = s_occ && (CGW'(s_gen) == CGW'(hgen_q));
	assign hit_fl  = s_occ && (CGW'(s_gen) == CGW'(fl_gen_q));
	assign fl_ptr_next = fl_ptr_q + 1'b1;

	always_comb begin
		state_d      = state_q;
		ctr_d        = ctr_q;
		free_count_d = free_count_q;
		pend_count_d = pend_count_q;
		fl_ptr_d     = fl_ptr_q;
		fl_idx_d     = fl_idx_q;
		fl_gen_d     = fl_gen_q;
		fin          = 1'b0;
		res_d        = '0;
		in_stall     = 1'b1;
		slot_we      = 1'b0;
		slot_waddr   = ctr_q;
		slot_wdata   = '0;
		slot_raddr   = '0;
		free_we      = 1'b0;
		free_waddr   = IW'(free_count_q);
		free_wdata   = '0;
		free_raddr   = IW'(free_count_q - 1'b1);
		pend_we      = 1'b0;
		pend_waddr   = PAW'(pend_count_q);
		pend_wdata   = {hidx_q, hgen_q};
		pend_raddr   = '0;
		res_valid    = 1'b0;
		res_out      = res_q;

		case (state_q)
			S_INIT: begin
				// Clearing pass: empty slot records, free stack in descending index order.
				slot_we    = 1'b1;
				slot_waddr = ctr_q;
				free_we    = 1'b1;
				free_waddr = ctr_q;
				free_wdata = {LAST_IDX - ctr_q, {GEN_BITS{1'b0}}};
				ctr_d      = ctr_q + 1'b1;
				if (ctr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (req_type)
						gha_pkg::REQ_ALLOC: begin
							if (free_count_q == '0) begin
								fin          = 1'b1;
								res_d.status = gha_pkg::ST_NOFREE;
							end else begin
								free_count_d = free_count_q - 1'b1;
								state_d      = S_ALLOC;
							end
						end
						gha_pkg::REQ_MARK, gha_pkg::REQ_LOOK: begin
							res_d.out_index = handle_index;
							slot_raddr      = IW'(handle_index);
							if (32'(handle_index) >= SLOT_COUNT) begin
								fin          = 1'b1;
								res_d.status = gha_pkg::ST_STALE;
							end else if (req_type == gha_pkg::REQ_MARK) begin
								state_d = S_MARK;
							end else begin
								state_d = S_LOOK;
							end
						end
						gha_pkg::REQ_FLUSH: begin
							pend_raddr = '0;
							fl_ptr_d   = '0;
							if (pend_count_q == '0) begin
								fin = 1'b1;
							end else begin
								state_d = S_FLP;
							end
						end
						gha_pkg::REQ_CLEAR: begin
							slot_raddr = '0;
							ctr_d      = '0;
							state_d    = S_CLR;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				slot_we              = 1'b1;
				slot_waddr           = a_idx;
				slot_wdata           = {1'b1, 1'b1, gen_new};
				fin                  = 1'b1;
				res_d.out_index      = gha_pkg::HIDX_W'(a_idx);
				res_d.out_generation = gha_pkg::HGEN_W'(gen_new);
			end
			S_MARK: begin
				fin             = 1'b1;
				res_d.out_index = hidx_q;
				if (!hit_req) begin
					res_d.status = gha_pkg::ST_STALE;
				end else if (pend_count_q == PW'(PENDING_DEPTH)) begin
					res_d.status = gha_pkg::ST_FULL;
				end else begin
					slot_we      = 1'b1;
					slot_waddr   = IW'(hidx_q);
					slot_wdata   = {1'b1, 1'b0, s_gen};
					pend_we      = 1'b1;
					pend_count_d = pend_count_q + 1'b1;
				end
			end
			S_LOOK: begin
				fin             = 1'b1;
				res_d.out_index = hidx_q;
				if (hit_req) begin
					res_d.present = 1'b1;
					res_d.alive   = s_alive;
				end else begin
					res_d.status = gha_pkg::ST_STALE;
				end
			end
			S_FLP: begin
				slot_raddr = IW'(p_idx);
				fl_idx_d   = IW'(p_idx);
				fl_gen_d   = p_gen;
				state_d    = S_FLS;
			end
			S_FLS: begin
				// The slot write lands before the next entry's slot read, so a handle
				// queued twice finds its slot already empty.
				if (hit_fl && !s_alive) begin
					slot_we    = 1'b1;
					slot_waddr = fl_idx_q;
					slot_wdata = {1'b0, 1'b0, s_gen};
					if (free_count_q != CW'(SLOT_COUNT)) begin
						free_we      = 1'b1;
						free_wdata   = {fl_idx_q, s_gen};
						free_count_d = free_count_q + 1'b1;
					end
				end
				if (fl_ptr_next == pend_count_q) begin
					pend_count_d = '0;
					fin          = 1'b1;
				end else begin
					pend_raddr = PAW'(fl_ptr_next);
					fl_ptr_d   = fl_ptr_next;
					state_d    = S_FLP;
				end
			end
			S_CLR: begin
				if (s_occ) begin
					slot_we    = 1'b1;
					slot_waddr = ctr_q;
					slot_wdata = {1'b0, 1'b0, s_gen};
					if (free_count_q != CW'(SLOT_COUNT)) begin
						free_we      = 1'b1;
						free_wdata   = {ctr_q, s_gen};
						free_count_d = free_count_q + 1'b1;
					end
				end
				if (ctr_q == LAST_IDX) begin
					fin = 1'b1;
				end else begin
					slot_raddr = ctr_q + 1'b1;
					ctr_d      = ctr_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		live_full        = CW'(SLOT_COUNT) - free_count_d;
		res_d.live_count = gha_pkg::LIVE_W'(live_full);

		if (fin) begin
			if (out_free) begin
				res_valid = 1'b1;
				res_out   = res_d;
				state_d   = S_IDLE;
			end else begin
				state_d = S_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ctr_q        <= '0;
			free_count_q <= CW'(SLOT_COUNT);
			pend_count_q <= '0;
			fl_ptr_q     <= '0;
		end else begin
			state_q      <= state_d;
			ctr_q        <= ctr_d;
			free_count_q <= free_count_d;
			pend_count_q <= pend_count_d;
			fl_ptr_q     <= fl_ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			hidx_q <= handle_index;
			hgen_q <= handle_generation;
		end
		fl_idx_q <= fl_idx_d;
		fl_gen_q <= fl_gen_d;
		if (fin && !out_free) begin
			res_q <= res_d;
		end
	end

endmodule

### hw/rtl/generational_handle_allocator_top.sv
// Top level of the generational handle allocator: memories, sequencer and result register.
//
//   channel   signals                                          direction
//   request   in_valid, in_stall, req_type, handle_index,      in (in_stall out)
//             handle_generation
//   result    out_valid, out_stall, status, out_index,         out (out_stall in)
//             out_generation, present, alive, live_count
//
// Allocate, mark and lookup first read the slot record or the free stack top; allocate and
// mark then write a slot record. Requests that need no memory read finish on acceptance.
// Flush reads, for each pending entry, the pending list and then its slot record; clear all
// handles one slot per cycle. After reset a clearing pass fills the free stack and empties
// the slot records; in_stall stays high meanwhile. A result waits in the output register
// under out_stall; the next request is still accepted, and its result is held in the
// sequencer until that register frees.
`timescale 1ns / 1ps

module generational_handle_allocator_top #(
	parameter int SLOT_COUNT    = gha_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS      = gha_pkg::GEN_BITS_DEF,
	parameter int PENDING_DEPTH = gha_pkg::PENDING_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [gha_pkg::REQ_W-1:0]   req_type,
	input  logic [gha_pkg::HIDX_W-1:0]  handle_index,
	input  logic [gha_pkg::HGEN_W-1:0]  handle_generation,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gha_pkg::STATUS_W-1:0] status,
	output logic [gha_pkg::HIDX_W-1:0]  out_index,
	output logic [gha_pkg::HGEN_W-1:0]  out_generation,
	output logic                        present,
	output logic                        alive,
	output logic [gha_pkg::LIVE_W-1:0]  live_count
);

	localparam int IW  = $clog2(SLOT_COUNT);
	localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int SW  = GEN_BITS + 2;
	localparam int FW  = IW + GEN_BITS;
	localparam int PDW = gha_pkg::HIDX_W + gha_pkg::HGEN_W;

	logic                slot_we, free_we, pend_we;
	logic [IW-1:0]       slot_waddr, slot_raddr, free_waddr, free_raddr;
	logic [SW-1:0]       slot_wdata, slot_rdata;
	logic [FW-1:0]       free_wdata, free_rdata;
	logic [PAW-1:0]      pend_waddr, pend_raddr;
	logic [PDW-1:0]      pend_wdata, pend_rdata;
	logic                out_free, res_valid, out_valid_q;
	gha_pkg::result_t    res_out, out_res_q;

	assign out_free = !out_valid_q || !out_stall;

	// Slot records: occupied, alive and generation.
	gha_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	gha_ram #(.DEPTH(SLOT_COUNT), .WIDTH(FW)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	gha_ram #(.DEPTH(PENDING_DEPTH), .WIDTH(PDW)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.raddr (pend_raddr),
		.rdata (pend_rdata)
	);

	gha_ctrl #(
		.SLOT_COUNT    (SLOT_COUNT),
		.GEN_BITS      (GEN_BITS),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.out_free          (out_free),
		.res_valid         (res_valid),
		.res_out           (res_out),
		.slot_we           (slot_we),
		.slot_waddr        (slot_waddr),
		.slot_wdata        (slot_wdata),
		.slot_raddr        (slot_raddr),
		.slot_rdata        (slot_rdata),
		.free_we           (free_we),
		.free_waddr        (free_waddr),
		.free_wdata        (free_wdata),
		.free_raddr        (free_raddr),
		.free_rdata        (free_rdata),
		.pend_we           (pend_we),
		.pend_waddr        (pend_waddr),
		.pend_wdata        (pend_wdata),
		.pend_raddr        (pend_raddr),
		.pend_rdata        (pend_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res_out;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign out_index      = out_res_q.out_index;
	assign out_generation = out_res_q.out_generation;
	assign present        = out_res_q.present;
	assign alive          = out_res_q.alive;
	assign live_count     = out_res_q.live_count;

endmodule
